[sv/hrm_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the heater relay modulation block
// no dependencies; imported by hrm_step, heater_relay_modulation_fsm and the testbench
package hrm_pkg;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_WORK = 2'd1,
        MODE_MOD  = 2'd2,
        MODE_KICK = 2'd3
    } t_mode;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned MIN_W     = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_OFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFETY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KICKSTART = 3'd5;

    localparam logic [DATA_W-1:0] AUTO_OFF_RESET  = 32'd3600000;
    localparam logic [DATA_W-1:0] SAFETY_RESET    = 32'd60000;
    localparam logic [DATA_W-1:0] KICKSTART_RESET = 32'd30000;

    // one control tick
    typedef struct packed {
        logic              target_reached;
        logic              enable_value;
        logic              enable_write;
        logic              time_valid;
        logic [MIN_W-1:0]  minute_of_day;
        logic [DATA_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic              sched_en;
        logic [MIN_W-1:0]  on_minute;
        logic [MIN_W-1:0]  off_minute;
        logic [DATA_W-1:0] auto_off_ms;
        logic [DATA_W-1:0] safety_ms;
        logic [DATA_W-1:0] kickstart_ms;
    } t_cfg;

    typedef struct packed {
        logic  heater_enabled;
        t_mode fsm_state;
        logic  relay_on;
    } t_result;

endpackage

[sv/hrm_step.sv]
`timescale 1ns / 1ps
// next-state logic for one control tick: enable update, schedule, mode step
// depends on hrm_pkg
module hrm_step
    import hrm_pkg::*;
#(
    parameter int unsigned CLOCK_BITS = 32
) (
    input  t_item                 i_item,
    input  t_cfg                  i_cfg,
    input  t_mode                 i_mode,
    input  logic                  i_enable,
    input  logic [CLOCK_BITS-1:0] i_mod_start,
    input  logic [CLOCK_BITS-1:0] i_kick_start,
    output t_mode                 o_mode,
    output logic                  o_enable,
    output logic                  o_mod_load,
    output logic                  o_kick_load,
    output logic [CLOCK_BITS-1:0] o_now,
    output t_result               o_result
);

    localparam int unsigned NOW_W = (CLOCK_BITS < DATA_W) ? CLOCK_BITS : DATA_W;
    localparam int unsigned CMP_W = (CLOCK_BITS > DATA_W) ? CLOCK_BITS : DATA_W;

    logic                  w_en_wr;
    logic                  w_en;
    logic [CLOCK_BITS-1:0] w_now;
    logic [CLOCK_BITS-1:0] w_mod_elapsed;
    logic [CLOCK_BITS-1:0] w_kick_elapsed;
    logic [DATA_W-1:0]     w_threshold;
    logic                  w_mod_due;
    logic                  w_kick_due;
    t_mode                 w_mode;
    logic                  w_relay;
    logic                  w_mod_load;
    logic                  w_kick_load;

    assign w_now = CLOCK_BITS'(i_item.now_ms[NOW_W-1:0]);

    // external write first, then schedule; off wins when both minutes match
    always_comb begin
        w_en_wr = i_item.enable_write ? i_item.enable_value : i_enable;
        w_en    = w_en_wr;
        if (i_cfg.sched_en && i_item.time_valid) begin
            if (i_item.minute_of_day == i_cfg.on_minute) begin
                w_en = 1'b1;
            end
            if (i_item.minute_of_day == i_cfg.off_minute) begin
                w_en = 1'b0;
            end
        end
    end

    assign w_threshold    = i_cfg.auto_off_ms - i_cfg.safety_ms;
    assign w_mod_elapsed  = w_now - i_mod_start;
    assign w_kick_elapsed = w_now - i_kick_start;
    assign w_mod_due  = CMP_W'(w_mod_elapsed) >= CMP_W'(w_threshold);
    assign w_kick_due = CMP_W'(w_kick_elapsed) >= CMP_W'(i_cfg.kickstart_ms);

    always_comb begin
        w_mode      = i_mode;
        w_relay     = 1'b0;
        w_mod_load  = 1'b0;
        w_kick_load = 1'b0;
        case (i_mode)
            MODE_OFF: begin
                if (w_en) begin
                    w_mode = MODE_WORK;
                end
            end
            MODE_WORK: begin
                w_relay = 1'b1;
                if (!w_en) begin
                    w_mode = MODE_OFF;
                end else if (i_item.target_reached) begin
                    w_mode     = MODE_MOD;
                    w_mod_load = 1'b1;
                end
            end
            MODE_MOD: begin
                if (!w_en) begin
                    w_mode = MODE_OFF;
                end else if (!i_item.target_reached) begin
                    w_mode = MODE_WORK;
                end else if (w_mod_due) begin
                    w_mode      = MODE_KICK;
                    w_kick_load = 1'b1;
                end
            end
            MODE_KICK: begin
                w_relay = 1'b1;
                if (!w_en) begin
                    w_mode = MODE_OFF;
                end else if (w_kick_due) begin
                    // pulse over: relay drops and the modulation timer restarts
                    w_relay    = 1'b0;
                    w_mode     = MODE_MOD;
                    w_mod_load = 1'b1;
                end
            end
            default: begin
                w_mode = MODE_OFF;
            end
        endcase
    end

    assign o_mode      = w_mode;
    assign o_enable    = w_en;
    assign o_mod_load  = w_mod_load;
    assign o_kick_load = w_kick_load;
    assign o_now       = w_now;
    assign o_result    = '{heater_enabled: w_en, fsm_state: w_mode, relay_on: w_relay};

endmodule

[sv/heater_relay_modulation_fsm.sv]
`timescale 1ns / 1ps
// heater relay modulation controller, top level with stream and config ports
// depends on hrm_pkg and hrm_step
//
//  channel   direction  handshake            payload
//  s_axis    in         i_s_tvalid/o_s_tready  tick fields in i_s_tdata (48 bits)
//  m_axis    out        o_m_tvalid/i_m_tready  result fields in o_m_tdata (8 bits)
//  cfg       in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// a beat is latched in the input register, stepped through hrm_step and its result
// registered when the result register is free: one beat per cycle while the output is not stalled.
// the mode step is the only path; state updates in the cycle the result is loaded.
// reset clears mode, enable bit, timestamps and both valid flags, config to its defaults.
// a stalled output holds its beat; the input register still takes one more beat.
module heater_relay_modulation_fsm
    import hrm_pkg::*;
#(
    parameter int unsigned CLOCK_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // now_ms[31:0], minute_of_day[42:32], time_valid[43], enable_write[44],
    // enable_value[45], target_reached[46], zero[47]
    input  logic [47:0]          i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // relay_on[0], fsm_state[2:1], heater_enabled[3], zero[7:4]
    output logic [7:0]           o_m_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned ITEM_W = $bits(t_item);
    localparam int unsigned RES_W  = $bits(t_result);

    logic                  r_in_valid;
    t_item                 r_in;
    logic                  r_out_valid;
    t_result               r_out;
    t_mode                 r_mode;
    logic                  r_enable;
    logic [CLOCK_BITS-1:0] r_mod_start;
    logic [CLOCK_BITS-1:0] r_kick_start;
    t_cfg                  r_cfg;

    logic                  w_advance;
    t_mode                 n_mode;
    logic                  n_enable;
    logic                  w_mod_load;
    logic                  w_kick_load;
    logic [CLOCK_BITS-1:0] w_now;
    t_result               n_out;

    assign w_advance   = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || w_advance;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {{(8 - RES_W){1'b0}}, r_out};
    assign o_cfg_ready = 1'b1;

    hrm_step #(
        .CLOCK_BITS (CLOCK_BITS)
    ) u_step (
        .i_item       (r_in),
        .i_cfg        (r_cfg),
        .i_mode       (r_mode),
        .i_enable     (r_enable),
        .i_mod_start  (r_mod_start),
        .i_kick_start (r_kick_start),
        .o_mode       (n_mode),
        .o_enable     (n_enable),
        .o_mod_load   (w_mod_load),
        .o_kick_load  (w_kick_load),
        .o_now        (w_now),
        .o_result     (n_out)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in <= t_item'(i_s_tdata[ITEM_W-1:0]);
        end
    end

    // result register and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_mode       <= MODE_OFF;
            r_enable     <= 1'b0;
            r_mod_start  <= '0;
            r_kick_start <= '0;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_enable    <= n_enable;
                if (w_mod_load) begin
                    r_mod_start <= w_now;
                end
                if (w_kick_load) begin
                    r_kick_start <= w_now;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    // configuration registers, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sched_en     <= 1'b0;
            r_cfg.on_minute    <= '0;
            r_cfg.off_minute   <= '0;
            r_cfg.auto_off_ms  <= AUTO_OFF_RESET;
            r_cfg.safety_ms    <= SAFETY_RESET;
            r_cfg.kickstart_ms <= KICKSTART_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCHED_EN:  r_cfg.sched_en     <= i_cfg_data[0];
                CFG_ON_MIN:    r_cfg.on_minute    <= i_cfg_data[MIN_W-1:0];
                CFG_OFF_MIN:   r_cfg.off_minute   <= i_cfg_data[MIN_W-1:0];
                CFG_AUTO_OFF:  r_cfg.auto_off_ms  <= i_cfg_data;
                CFG_SAFETY:    r_cfg.safety_ms    <= i_cfg_data;
                CFG_KICKSTART: r_cfg.kickstart_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

[verif/heater_relay_modulation_fsm_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for heater_relay_modulation_fsm: directed table, then random phases
// depends on hrm_pkg and the rtl top; predicts every result beat and compares field by field
module heater_relay_modulation_fsm_test;
    import hrm_pkg::*;

    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_TICKS = 70;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned PRINT_CAP   = 40;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

    // tick flags, packed as in t_item above minute_of_day
    localparam logic [3:0] F_TV = 4'b0001;
    localparam logic [3:0] F_EW = 4'b0010;
    localparam logic [3:0] F_EV = 4'b0100;
    localparam logic [3:0] F_TR = 4'b1000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [47:0]          i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [7:0]           o_m_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;

    heater_relay_modulation_fsm dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    t_cfg              setting;
    t_mode             mode_now;
    logic              heat_en;
    logic [DATA_W-1:0] mod_start_ms;
    logic [DATA_W-1:0] kick_start_ms;

    t_result     due_results[$];
    int unsigned error_count;
    int unsigned beats_seen;
    logic        no_idle;
    int unsigned idle_cycles;

    typedef struct {
        logic                 is_set;
        t_item                tick;
        logic [CFG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    val;
        logic                 has_exp;
        t_result              exp_res;
    } t_row;

    t_row plan[$];

    function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [DATA_W-1:0] val);
        case (idx)
            CFG_SCHED_EN:  setting.sched_en     = val[0];
            CFG_ON_MIN:    setting.on_minute    = val[MIN_W-1:0];
            CFG_OFF_MIN:   setting.off_minute   = val[MIN_W-1:0];
            CFG_AUTO_OFF:  setting.auto_off_ms  = val;
            CFG_SAFETY:    setting.safety_ms    = val;
            CFG_KICKSTART: setting.kickstart_ms = val;
            default: ;
        endcase
    endfunction

    function automatic t_result step_heater(input t_item it);
        t_result           r;
        logic [DATA_W-1:0] thresh;
        r.relay_on = 1'b0;
        if (it.enable_write)
            heat_en = it.enable_value;
        if (setting.sched_en && it.time_valid) begin
            // on then off, so equal minutes leave the bit cleared
            if (it.minute_of_day == setting.on_minute)
                heat_en = 1'b1;
            if (it.minute_of_day == setting.off_minute)
                heat_en = 1'b0;
        end
        thresh = setting.auto_off_ms - setting.safety_ms;
        case (mode_now)
            MODE_OFF: begin
                r.relay_on = 1'b0;
                if (heat_en)
                    mode_now = MODE_WORK;
            end
            MODE_WORK: begin
                r.relay_on = 1'b1;
                if (!heat_en) begin
                    mode_now = MODE_OFF;
                end else if (it.target_reached) begin
                    mode_now     = MODE_MOD;
                    mod_start_ms = it.now_ms;
                end
            end
            MODE_MOD: begin
                r.relay_on = 1'b0;
                if (!heat_en) begin
                    mode_now = MODE_OFF;
                end else if (!it.target_reached) begin
                    mode_now = MODE_WORK;
                end else if (DATA_W'(it.now_ms - mod_start_ms) >= thresh) begin
                    kick_start_ms = it.now_ms;
                    mode_now      = MODE_KICK;
                end
            end
            default: begin
                r.relay_on = 1'b1;
                if (!heat_en) begin
                    mode_now = MODE_OFF;
                end else if (DATA_W'(it.now_ms - kick_start_ms) >= setting.kickstart_ms) begin
                    // pulse over: relay drops this tick and modulation restarts
                    r.relay_on   = 1'b0;
                    mod_start_ms = it.now_ms;
                    mode_now     = MODE_MOD;
                end
            end
        endcase
        r.fsm_state      = mode_now;
        r.heater_enabled = heat_en;
        return r;
    endfunction

    function automatic t_result outcome(input logic relay, input t_mode st, input logic en);
        t_result r;
        r.relay_on       = relay;
        r.fsm_state      = st;
        r.heater_enabled = en;
        return r;
    endfunction

    function automatic void plan_tick(input logic [DATA_W-1:0] now, input logic [MIN_W-1:0] minute,
                                      input logic [3:0] flags, input logic has_exp,
                                      input t_result er);
        t_row row;
        row.is_set  = 1'b0;
        row.tick    = {flags, minute, now};
        row.idx     = CFG_SCHED_EN;
        row.val     = '0;
        row.has_exp = has_exp;
        row.exp_res = er;
        plan.push_back(row);
    endfunction

    function automatic void plan_set(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [DATA_W-1:0] val);
        t_row row;
        row.is_set  = 1'b1;
        row.tick    = '0;
        row.idx     = idx;
        row.val     = val;
        row.has_exp = 1'b0;
        row.exp_res = '0;
        plan.push_back(row);
    endfunction

    function automatic int unsigned draw_wait();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    task automatic note_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        if (error_count < PRINT_CAP)
            $display("mismatch at beat %0d, %s: got %0h expected %0h",
                     beats_seen, what, got, want);
        error_count++;
    endtask

    task automatic send_tick(input t_item it, input logic has_exp, input t_result er);
        int unsigned gap;
        t_result     pred;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  = {1'b0, it};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        pred = step_heater(it);
        due_results.push_back(has_exp ? er : pred);
    endtask

    // stop sending and let every outstanding beat come back
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_setting(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // result side
    initial begin : sink
        int unsigned stall;
        t_result     got;
        t_result     want;
        i_m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = draw_wait();
            if (stall > 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            got = t_result'(o_m_tdata[3:0]);
            if (due_results.size() == 0) begin
                note_error("result beat with nothing outstanding", 32'(o_m_tdata), 32'd0);
            end else begin
                want = due_results.pop_front();
                if (got.relay_on !== want.relay_on)
                    note_error("relay_on", 32'(got.relay_on), 32'(want.relay_on));
                if (got.fsm_state !== want.fsm_state)
                    note_error("fsm_state", 32'(got.fsm_state), 32'(want.fsm_state));
                if (got.heater_enabled !== want.heater_enabled)
                    note_error("heater_enabled", 32'(got.heater_enabled),
                               32'(want.heater_enabled));
            end
            beats_seen++;
        end
    end

    // watchdog on cycles where no channel moves a beat
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        t_row              row;
        t_item             it;
        logic [DATA_W-1:0] now;
        logic              tr_level;
        logic              se;
        logic [MIN_W-1:0]  onm;
        logic [MIN_W-1:0]  offm;
        logic [DATA_W-1:0] ao;
        logic [DATA_W-1:0] sm;
        logic [DATA_W-1:0] ks;
        int unsigned       pause_at;
        int unsigned       pick;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SCHED_EN;
        i_cfg_data  = '0;
        no_idle     = 1'b0;
        error_count = 0;
        beats_seen  = 0;
        idle_cycles = 0;

        setting.sched_en     = 1'b0;
        setting.on_minute    = '0;
        setting.off_minute   = '0;
        setting.auto_off_ms  = AUTO_OFF_RESET;
        setting.safety_ms    = SAFETY_RESET;
        setting.kickstart_ms = KICKSTART_RESET;
        mode_now      = MODE_OFF;
        heat_en       = 1'b0;
        mod_start_ms  = '0;
        kick_start_ms = '0;

        // directed table, starting from reset values (threshold 3540000)
        plan_tick(32'd0, 11'd0, F_TV, 1'b1, outcome(1'b0, MODE_OFF, 1'b0));
        plan_tick(32'd10, 11'd5, F_TV | F_EW | F_EV, 1'b1, outcome(1'b0, MODE_WORK, 1'b1));
        plan_tick(32'd100, 11'd5, F_TR, 1'b1, outcome(1'b1, MODE_MOD, 1'b1));
        plan_tick(32'd200, 11'd5, 4'b0000, 1'b1, outcome(1'b0, MODE_WORK, 1'b1));
        plan_tick(32'd300, 11'd5, F_TR, 1'b0, '0);
        plan_set(CFG_AUTO_OFF, 32'd1000);
        plan_set(CFG_SAFETY, 32'd200);
        plan_tick(32'd1099, 11'd5, F_TR, 1'b0, '0);
        plan_tick(32'd1100, 11'd5, F_TR, 1'b0, '0);
        plan_set(CFG_KICKSTART, 32'd50);
        plan_tick(32'd1149, 11'd5, F_TR, 1'b0, '0);
        plan_tick(32'd1150, 11'd5, F_TR, 1'b0, '0);
        plan_tick(32'd1950, 11'd5, F_TR, 1'b0, '0);
        // kickstart ends at the top of the clock, next kickstart across the wrap
        plan_tick(32'hFFFF_FFFF, 11'd5, F_TR, 1'b0, '0);
        plan_tick(32'd799, 11'd5, F_TR, 1'b0, '0);
        plan_tick(32'd900, 11'd5, F_EW | F_TR, 1'b1, outcome(1'b1, MODE_OFF, 1'b0));
        plan_set(CFG_SCHED_EN, 32'd1);
        plan_set(CFG_ON_MIN, 32'd600);
        plan_set(CFG_OFF_MIN, 32'd600);
        plan_tick(32'd1000, 11'd600, F_TV | F_EW | F_EV, 1'b1, outcome(1'b0, MODE_OFF, 1'b0));
        plan_set(CFG_ON_MIN, 32'd1439);
        plan_set(CFG_OFF_MIN, 32'd0);
        plan_tick(32'd1010, 11'd1439, 4'b0000, 1'b1, outcome(1'b0, MODE_OFF, 1'b0));
        plan_tick(32'd1020, 11'd1439, F_TV, 1'b1, outcome(1'b0, MODE_WORK, 1'b1));
        plan_tick(32'd2000, 11'd2047, F_TV | F_TR, 1'b0, '0);
        plan_set(CFG_SPARE6, 32'hFFFF_FFFF);
        plan_set(CFG_SPARE7, 32'hFFFF_FFFF);
        // threshold wraps to all ones
        plan_set(CFG_AUTO_OFF, 32'd0);
        plan_set(CFG_SAFETY, 32'd1);
        plan_tick(32'd5, 11'd5, F_TR, 1'b0, '0);
        plan_tick(32'd1999, 11'd5, F_TR, 1'b0, '0);
        plan_tick(32'd2010, 11'd0, F_TV | F_TR, 1'b1, outcome(1'b1, MODE_OFF, 1'b0));
        plan_tick(32'hFFFF_FFFF, 11'd2047, 4'b1111, 1'b1, outcome(1'b0, MODE_WORK, 1'b1));
        plan_tick(32'd0, 11'd5, F_EW, 1'b1, outcome(1'b1, MODE_OFF, 1'b0));
        plan_tick(32'd1, 11'd5, F_EW | F_EV, 1'b1, outcome(1'b0, MODE_WORK, 1'b1));
        plan_tick(32'd2, 11'd5, F_TR, 1'b0, '0);
        plan_tick(32'd3, 11'd0, F_TV | F_TR, 1'b1, outcome(1'b0, MODE_OFF, 1'b0));
        plan_set(CFG_ON_MIN, 32'hFFFF_FFFF);
        plan_tick(32'd4, 11'd2047, F_TV, 1'b1, outcome(1'b0, MODE_WORK, 1'b1));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[n]) begin
            row = plan[n];
            if (row.is_set) begin
                drain();
                write_setting(row.idx, row.val);
            end else begin
                send_tick(row.tick, row.has_exp, row.exp_res);
            end
        end

        // random phases, each with its own register setting
        now      = $urandom;
        tr_level = 1'b1;
        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            drain();
            no_idle = (phase % 3 == 1);
            case (phase)
                0: begin
                    se = 1'b0; onm = '0; offm = '0; ao = '0; sm = '0; ks = '0;
                end
                1: begin
                    se = 1'b1; onm = 11'd1439; offm = 11'd1439;
                    ao = 32'hFFFF_FFFF; sm = 32'hFFFF_FFFF; ks = 32'hFFFF_FFFF;
                end
                2: begin
                    se = 1'b1; onm = MIN_W'($urandom_range(0, 1439));
                    offm = MIN_W'($urandom_range(0, 1439));
                    ao = $urandom_range(0, 3000);
                    sm = ao + $urandom_range(1, 500);
                    ks = $urandom_range(0, 400);
                end
                5: begin
                    se = 1'($urandom_range(0, 1)); onm = MIN_W'($urandom_range(0, 1439));
                    offm = MIN_W'($urandom_range(0, 1439));
                    ao = $urandom; sm = $urandom; ks = $urandom;
                end
                default: begin
                    se = ($urandom_range(0, 2) != 0);
                    onm = MIN_W'($urandom_range(0, 1439));
                    offm = MIN_W'($urandom_range(0, 1439));
                    ao = $urandom_range(200, 3000);
                    sm = $urandom_range(0, 300);
                    ks = $urandom_range(0, 400);
                end
            endcase
            if (phase == 3)
                now = 32'hFFFF_F000;
            // junk above the register width is dropped by the block
            write_setting(CFG_SCHED_EN, ($urandom_range(0, 1) ? ($urandom << 1) : 32'd0) | se);
            write_setting(CFG_ON_MIN, ($urandom_range(0, 1) ? ($urandom << MIN_W) : 32'd0) | onm);
            write_setting(CFG_OFF_MIN, ($urandom_range(0, 1) ? ($urandom << MIN_W) : 32'd0) | offm);
            write_setting(CFG_AUTO_OFF, ao);
            write_setting(CFG_SAFETY, sm);
            write_setting(CFG_KICKSTART, ks);

            pause_at = $urandom_range(10, PHASE_TICKS - 10);
            for (int unsigned k = 0; k < PHASE_TICKS; k++) begin
                if (k == pause_at)
                    drain();
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    now = $urandom;
                else if (pick == 1)
                    now = now + $urandom_range(0, 5000);
                else
                    now = now + $urandom_range(0, 300);
                if ($urandom_range(0, 7) == 0)
                    tr_level = ~tr_level;
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    it.minute_of_day = setting.on_minute;
                else if (pick == 3)
                    it.minute_of_day = setting.off_minute;
                else if (pick == 4)
                    it.minute_of_day = MIN_W'($urandom_range(1440, 2047));
                else
                    it.minute_of_day = MIN_W'($urandom_range(0, 1439));
                it.now_ms         = now;
                it.time_valid     = ($urandom_range(0, 6) != 0);
                it.enable_write   = ($urandom_range(0, 11) == 0);
                it.enable_value   = ($urandom_range(0, 3) != 0);
                it.target_reached = tr_level;
                send_tick(it, 1'b0, '0);
            end
        end

        drain();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
sv/hrm_pkg.sv
sv/hrm_step.sv
sv/heater_relay_modulation_fsm.sv
verif/heater_relay_modulation_fsm_test.sv
